// File: rtl/svf2_pkg.sv
// Shared types, codes and saturation helpers for the oversampled state-variable filter.
package svf2_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned RecipWidth = 31;
  localparam int unsigned ModeWidth = 2;
  localparam int unsigned IndexWidth = 2;

  // Configuration register indexes
  localparam logic [IndexWidth-1:0] CFG_CUTOFF = 2'd0;
  localparam logic [IndexWidth-1:0] CFG_RECIP_Q = 2'd1;
  localparam logic [IndexWidth-1:0] CFG_OUT_MODE = 2'd2;

  // Output select codes
  localparam logic [ModeWidth-1:0] MODE_LOW = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_HIGH = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_BAND = 2'd2;
  localparam logic [ModeWidth-1:0] MODE_NOTCH = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_UPD_LOW,
    ST_SUB_IN,
    ST_UPD_HIGH,
    ST_MUL_FH,
    ST_UPD_BAND,
    ST_ACC,
    ST_OUT
  } state_t;

  // Multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_FB,  // cutoff * band
    MUL_RB,  // scaled recip_q * band
    MUL_FH   // cutoff * high
  } mul_sel_t;

  typedef struct packed {
    logic     load_x;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_low;
    logic     upd_diff;
    logic     upd_high;
    logic     upd_band;
    logic     acc_en;
    logic     acc_first;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Clamp a 33-bit signed value to the signed 32-bit range.
  function automatic logic signed [DataWidth-1:0] sat33(input logic signed [DataWidth:0] v);
    logic signed [DataWidth-1:0] r;
    if (v[DataWidth] != v[DataWidth-1]) begin
      r = v[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
    end else begin
      r = v[DataWidth-1:0];
    end
    return r;
  endfunction

  // Saturating sum and difference of two 32-bit signed values.
  function automatic logic signed [DataWidth-1:0] sat_add(input logic signed [DataWidth-1:0] a,
                                                          input logic signed [DataWidth-1:0] b);
    logic signed [DataWidth:0] s;
    s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
    return sat33(s);
  endfunction

  function automatic logic signed [DataWidth-1:0] sat_sub(input logic signed [DataWidth-1:0] a,
                                                          input logic signed [DataWidth-1:0] b);
    logic signed [DataWidth:0] s;
    s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
    return sat33(s);
  endfunction

endpackage

// File: rtl/svf2_ctrl.sv
// Sequencer that steps the shared multiplier and the update registers through two filter passes.
module svf2_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            idle,
  input  svf2_pkg::status_t status,
  output svf2_pkg::cmd_t  cmd
);

  svf2_pkg::state_t state;
  svf2_pkg::state_t state_next;
  logic             second_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svf2_pkg::ST_IDLE;
      second_pass <= 1'b0;
    end else begin
      state <= state_next;
      if (state == svf2_pkg::ST_ACC) begin
        second_pass <= ~second_pass;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      svf2_pkg::ST_IDLE: begin
        if (in_valid) state_next = svf2_pkg::ST_MUL_FB;
      end
      svf2_pkg::ST_MUL_FB:   state_next = svf2_pkg::ST_UPD_LOW;
      svf2_pkg::ST_UPD_LOW:  state_next = svf2_pkg::ST_SUB_IN;
      svf2_pkg::ST_SUB_IN:   state_next = svf2_pkg::ST_UPD_HIGH;
      svf2_pkg::ST_UPD_HIGH: state_next = svf2_pkg::ST_MUL_FH;
      svf2_pkg::ST_MUL_FH:   state_next = svf2_pkg::ST_UPD_BAND;
      svf2_pkg::ST_UPD_BAND: state_next = svf2_pkg::ST_ACC;
      svf2_pkg::ST_ACC: begin
        state_next = second_pass ? svf2_pkg::ST_OUT : svf2_pkg::ST_MUL_FB;
      end
      svf2_pkg::ST_OUT: begin
        if (status.out_free) state_next = svf2_pkg::ST_IDLE;
      end
      default: state_next = svf2_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = svf2_pkg::MUL_FB;
    idle = 1'b0;
    unique case (state)
      svf2_pkg::ST_IDLE: begin
        idle = 1'b1;
        cmd.load_x = in_valid;
      end
      svf2_pkg::ST_MUL_FB: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = svf2_pkg::MUL_FB;
      end
      svf2_pkg::ST_UPD_LOW: begin
        cmd.upd_low = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = svf2_pkg::MUL_RB;
      end
      svf2_pkg::ST_SUB_IN:   cmd.upd_diff = 1'b1;
      svf2_pkg::ST_UPD_HIGH: cmd.upd_high = 1'b1;
      svf2_pkg::ST_MUL_FH: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = svf2_pkg::MUL_FH;
      end
      svf2_pkg::ST_UPD_BAND: cmd.upd_band = 1'b1;
      svf2_pkg::ST_ACC: begin
        cmd.acc_en = 1'b1;
        cmd.acc_first = ~second_pass;
      end
      svf2_pkg::ST_OUT: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_second_pass_ends: assert property (@(posedge clk) disable iff (rst)
    (state == svf2_pkg::ST_ACC && second_pass) |=> (state == svf2_pkg::ST_OUT))
    else $error("second pass did not hand off to output");

  a_start_first_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.load_x |=> (state == svf2_pkg::ST_MUL_FB && !second_pass))
    else $error("new sample did not start on the first pass");
`endif

endmodule

// File: rtl/svf2_dp.sv
// Filter datapath: configuration, shared multiplier, state registers and output register.
module svf2_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic signed [31:0]        sample_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        sample_out,
  input  svf2_pkg::cmd_t            cmd,
  output svf2_pkg::status_t         status
);

  logic signed [31:0] cutoff_coeff;
  logic        [30:0] recip_q;
  logic        [1:0]  out_mode;

  logic signed [31:0] low_acc;
  logic signed [31:0] high_val;
  logic signed [31:0] band_acc;
  logic signed [31:0] x;
  logic signed [63:0] prod;
  logic signed [31:0] acc;

  logic signed [31:0] rqs;
  logic               rq_shift;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] mul_q;
  logic signed [31:0] scaled;
  logic signed [31:0] tap;
  logic signed [31:0] tap_half;

  // Scaled reciprocal: drop bit 30 into a one-place shift, keep the rest doubled.
  assign rqs = {1'b0, recip_q[29:0], 1'b0};
  assign rq_shift = recip_q[30];

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_coeff <= '0;
      recip_q <= '0;
      out_mode <= svf2_pkg::MODE_LOW;
    end else if (cfg_write) begin
      unique case (cfg_index)
        svf2_pkg::CFG_CUTOFF:   cutoff_coeff <= cfg_data;
        svf2_pkg::CFG_RECIP_Q:  recip_q <= cfg_data[30:0];
        svf2_pkg::CFG_OUT_MODE: out_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      svf2_pkg::MUL_FB: begin
        mul_a = cutoff_coeff;
        mul_b = band_acc;
      end
      svf2_pkg::MUL_RB: begin
        mul_a = rqs;
        mul_b = band_acc;
      end
      svf2_pkg::MUL_FH: begin
        mul_a = cutoff_coeff;
        mul_b = high_val;
      end
      default: begin
        mul_a = cutoff_coeff;
        mul_b = band_acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.load_x) x <= sample_in;
  end

  // Fractional product: floor(p / 2^31), clamped (only -1 * -1 overflows).
  assign mul_q = svf2_pkg::sat33(prod[63:31]);
  assign scaled = rq_shift ? svf2_pkg::sat33({mul_q, 1'b0}) : mul_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_acc <= '0;
      high_val <= '0;
      band_acc <= '0;
    end else begin
      if (cmd.upd_low) low_acc <= svf2_pkg::sat_add(low_acc, mul_q);
      if (cmd.upd_diff) high_val <= svf2_pkg::sat_sub(x, scaled);
      if (cmd.upd_high) high_val <= svf2_pkg::sat_sub(high_val, low_acc);
      if (cmd.upd_band) band_acc <= svf2_pkg::sat_add(band_acc, mul_q);
    end
  end

  always_comb begin
    unique case (out_mode)
      svf2_pkg::MODE_LOW:   tap = low_acc;
      svf2_pkg::MODE_HIGH:  tap = high_val;
      svf2_pkg::MODE_BAND:  tap = band_acc;
      svf2_pkg::MODE_NOTCH: tap = '0;
      default:              tap = '0;
    endcase
  end

  assign tap_half = tap >>> 1;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc <= cmd.acc_first ? tap_half : svf2_pkg::sat_add(acc, tap_half);
    end
    if (cmd.out_load) sample_out <= acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register loaded over a waiting result");
`endif

endmodule

// File: rtl/state_variable_filter_2x_top.sv
// Top level of the two-times oversampled state-variable filter.
// Chamberlin state-variable filter on Q1.31 samples, run twice per input sample. Each
// pass updates low, high and band through one shared 32x32 multiplier, three products per
// pass, with every add, subtract and shift clamped to the 32-bit range; the selected tap
// (out_mode: low, high, band, or zero for notch) is halved after each pass and the two
// halves summed. A sample is taken in the idle state, then runs seven controller steps per
// pass (multiply, low update with the second multiply, input difference, high update,
// multiply, band update, accumulate) and one step to hand the result to the output
// register; the steps share the one multiplier and its product register, and no new sample
// is taken before the sequencer is back in idle. The result sits in the output register
// while the next sample is taken; the block holds before handing over a new result only
// while the previous one is still stalled. Write configuration only while idle:
// index 0 cutoff_coeff, 1 recip_q, 2 out_mode; other indexes are dropped. Reset clears the
// registers and the filter state.
module state_variable_filter_2x_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] sample_out,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  svf2_pkg::cmd_t    cmd;
  svf2_pkg::status_t status;
  logic              idle;

  // Take a new sample only when the sequencer is idle.
  assign in_stall = !idle;

  svf2_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .idle     (idle),
    .status   (status),
    .cmd      (cmd)
  );

  svf2_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cmd        (cmd),
    .status     (status)
  );

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a sample is still in work");
`endif

endmodule

// File: test/tb_state_variable_filter_2x_top.sv
// Self-checking testbench for the two-times oversampled state-variable filter.
module tb_state_variable_filter_2x_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index past the register list: the block drops writes to it
  localparam logic [svf2_pkg::IndexWidth-1:0] CFG_SPARE = 2'd3;
  // Above this recip_q value the scaled damping term takes one extra left shift
  localparam logic [30:0] RQ_SPLIT = 31'h3fffffff;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] sample_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] sample_out;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // Predictor copy of the configuration and the filter state
  logic signed [31:0] cut_coeff = '0;
  logic [30:0]        recip_raw = '0;
  logic [1:0]         out_sel = '0;
  logic signed [31:0] svf_low = '0;
  logic signed [31:0] svf_high = '0;
  logic signed [31:0] svf_band = '0;

  logic signed [31:0] pending_sample_out[$];
  logic signed [31:0] last_sample = '0;
  int unsigned        mismatch_count = 0;
  bit                 idle_enable = 1'b1;
  int unsigned        out_hold_cycles = 0;

  state_variable_filter_2x_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; the slowest legal run is a fraction of this
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > SAT_HI) return S_MAX;
    if (v < SAT_LO) return S_MIN;
    return v[31:0];
  endfunction

  // Fractional 1.31 product, floored; only -1 * -1 overflows and clamps to max
  function automatic logic signed [31:0] frac_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 31);
  endfunction

  // One filter update; returns the tap picked by out_mode
  function automatic logic signed [31:0] filter_pass(input logic signed [31:0] x,
                                                     input logic signed [31:0] rqs,
                                                     input bit rq_shift);
    logic signed [31:0] damp;
    svf_low = clamp32(longint'(svf_low) + longint'(frac_mul(cut_coeff, svf_band)));
    damp = frac_mul(rqs, svf_band);
    if (rq_shift) damp = clamp32(longint'(damp) * 2);
    svf_high = clamp32(longint'(clamp32(longint'(x) - longint'(damp))) - longint'(svf_low));
    svf_band = clamp32(longint'(svf_band) + longint'(frac_mul(cut_coeff, svf_high)));
    case (out_sel)
      svf2_pkg::MODE_LOW:  return svf_low;
      svf2_pkg::MODE_HIGH: return svf_high;
      svf2_pkg::MODE_BAND: return svf_band;
      default:             return '0;  // notch is never formed
    endcase
  endfunction

  // Full sample: two passes, each tap halved (floor), halves added with clamping
  function automatic logic signed [31:0] filter_sample(input logic signed [31:0] x);
    logic signed [31:0] rqs;
    logic signed [31:0] first_half;
    logic signed [31:0] second_half;
    bit                 rq_shift;
    rq_shift = (recip_raw > RQ_SPLIT);
    rqs = {1'b0, recip_raw[29:0], 1'b0};
    first_half = filter_pass(x, rqs, rq_shift) >>> 1;
    second_half = filter_pass(x, rqs, rq_shift) >>> 1;
    return clamp32(longint'(first_half) + longint'(second_half));
  endfunction

  // ---------------------------------------------------------------------------
  // Random picks
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      last_sample = $urandom;
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0: last_sample = S_MAX;
        1: last_sample = S_MIN;
        2: last_sample = '0;
        default: last_sample = -32'sd1;
      endcase
    end else if (r < 8) begin
      // small signal keeps the filter out of saturation
      last_sample = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    end
    // otherwise hold the previous value: step-like input
    return last_sample;
  endfunction

  function automatic logic signed [31:0] pick_cutoff();
    case ($urandom_range(0, 5))
      0: return S_MIN;
      1: return S_MAX;
      2: return $urandom_range(0, 32'h0fffffff);
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_recip();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return RQ_SPLIT;
      2: return RQ_SPLIT + 31'd1;
      3: return 31'h7fffffff;
      default: return 31'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one sample, hold it until the transfer, record the prediction,
  // then maybe leave a gap. Valid stays high when no gap follows.
  task automatic send_sample(input logic signed [31:0] x);
    int unsigned gap;
    in_valid <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    pending_sample_out.push_back(filter_sample(x));
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      sample_in <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_sample_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only ever issued from idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      svf2_pkg::CFG_CUTOFF:   cut_coeff = val;
      svf2_pkg::CFG_RECIP_Q:  recip_raw = val[30:0];
      svf2_pkg::CFG_OUT_MODE: out_sel = val[1:0];
      default: ;  // dropped by the block
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when a test asks for one
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_hold_cycles > 0) begin
        out_stall <= 1'b1;
        out_hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        stall_left = idle_len();
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sample_out.size() == 0) begin
        report_error($sformatf("sample_out %h with no result pending", sample_out));
      end else begin
        want = pending_sample_out.pop_front();
        if (sample_out !== want)
          report_error($sformatf("sample_out %h, predicted %h", sample_out, want));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at reset: zero cutoff keeps every tap at zero except high
  task automatic test_reset_defaults();
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
  endtask

  // A write past the register list must leave the settings untouched
  task automatic test_register_index();
    write_reg(svf2_pkg::CFG_CUTOFF, 32'h20000000);
    write_reg(svf2_pkg::CFG_RECIP_Q, 32'h20000000);
    write_reg(svf2_pkg::CFG_OUT_MODE, {30'd0, svf2_pkg::MODE_BAND});
    send_sample(32'sh40000000);
    send_sample(-32'sh40000000);
    write_reg(CFG_SPARE, 32'hffffffff);
    send_sample(32'sh40000000);
    send_sample(-32'sh40000000);
  endtask

  // Full-scale cutoff and damping with full-scale input, every output select;
  // drives the taps into saturation and the -1 * -1 product
  task automatic test_mode_extremes();
    logic [1:0] modes[4];
    modes = '{svf2_pkg::MODE_LOW, svf2_pkg::MODE_HIGH, svf2_pkg::MODE_BAND,
              svf2_pkg::MODE_NOTCH};
    write_reg(svf2_pkg::CFG_CUTOFF, S_MIN);
    write_reg(svf2_pkg::CFG_RECIP_Q, 32'h7fffffff);
    foreach (modes[i]) begin
      write_reg(svf2_pkg::CFG_OUT_MODE, {30'd0, modes[i]});
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MIN);
    end
  endtask

  // Either side of the recip_q split between plain and shifted damping
  task automatic test_recip_split();
    write_reg(svf2_pkg::CFG_CUTOFF, 32'h30000000);
    write_reg(svf2_pkg::CFG_OUT_MODE, {30'd0, svf2_pkg::MODE_HIGH});
    write_reg(svf2_pkg::CFG_RECIP_Q, {1'b0, RQ_SPLIT});
    send_sample(S_MAX);
    send_sample(-32'sh12345678);
    write_reg(svf2_pkg::CFG_RECIP_Q, {1'b0, RQ_SPLIT + 31'd1});
    send_sample(S_MAX);
    send_sample(-32'sh12345678);
  endtask

  // Hold the output side off for a long stretch while samples keep coming,
  // so the block fills and stalls its input
  task automatic test_output_hold_off();
    write_reg(svf2_pkg::CFG_CUTOFF, 32'h08000000);
    write_reg(svf2_pkg::CFG_RECIP_Q, 32'h50000000);
    write_reg(svf2_pkg::CFG_OUT_MODE, {30'd0, svf2_pkg::MODE_LOW});
    idle_enable = 1'b0;
    out_hold_cycles = 300;
    repeat (10) send_sample(pick_sample());
    idle_enable = 1'b1;
  endtask

  // Random settings per phase, random samples within; each phase boundary
  // drains the block before rewriting the registers. Some phases run
  // without any idling.
  task automatic test_random_phases();
    int unsigned phase;
    for (phase = 0; phase < 15; phase++) begin
      write_reg(svf2_pkg::CFG_CUTOFF, pick_cutoff());
      write_reg(svf2_pkg::CFG_RECIP_Q, {1'($urandom), pick_recip()});
      write_reg(svf2_pkg::CFG_OUT_MODE, $urandom);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom);
      idle_enable = (phase % 4 != 1);
      repeat (96) send_sample(pick_sample());
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_index();
    test_mode_extremes();
    test_recip_split();
    test_output_hold_off();
    test_random_phases();

    // drain, then give a stray extra result time to show up
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
